>>> rtl/core/socc_pkg.sv
// Package for the steering override command controller.
// Holds the item kind, status and config index codes, the command byte values,
// the PWM and hold constants, the data widths and the result layout. No dependencies.
package socc_pkg;

  typedef enum logic [1:0] {
    REQ_HOST   = 2'd0,
    REQ_SWITCH = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_SPARE  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    REMOTE_NONE  = 2'd0,
    REMOTE_START = 2'd1,
    REMOTE_STOP  = 2'd2,
    REMOTE_RSVD  = 2'd3
  } remote_code_e;

  typedef enum logic [0:0] {
    CFG_LONG_HOLD   = 1'b0,
    CFG_FAST_REPORT = 1'b1
  } cfg_index_e;

  localparam logic [7:0] FwdLowByte    = 8'd30;
  localparam logic [7:0] FwdHighByte   = 8'd65;
  localparam logic [7:0] RelayOnByte   = 8'h79;  // 'y'
  localparam logic [7:0] RelayOffByte  = 8'h6e;  // 'n'
  localparam logic [7:0] CancelByte    = 8'd70;
  localparam logic [7:0] OvrLowByte    = 8'd71;
  localparam logic [7:0] OvrHighByte   = 8'd87;
  localparam logic [7:0] StartByte     = 8'd10;
  localparam logic [7:0] StopByte      = 8'd20;

  localparam logic [10:0] PwmBase      = 11'd1100;  // 71*50 - 2450
  localparam logic [5:0]  PwmStep      = 6'd50;
  localparam logic [10:0] PwmReset     = 11'd1500;

  localparam logic [5:0] HoldLongFast  = 6'd50;
  localparam logic [5:0] HoldLongSlow  = 6'd10;
  localparam logic [5:0] HoldShortFast = 6'd10;
  localparam logic [5:0] HoldShortSlow = 6'd2;

  localparam int unsigned InDataWidth  = 24;
  localparam int unsigned OutDataWidth = 32;

  typedef struct packed {
    logic [2:0]   pad;
    remote_code_e remote_status;
    logic [7:0]   forward_byte;
    logic         forward_valid;
    logic         relay_on;
    logic         override_active;
    logic [15:0]  pwm_us;
  } result_t;

endpackage

>>> rtl/core/steering_override_command_controller.sv
// Top level of the steering override command controller.
// Decodes host, switch and tick items and registers one result per item.
// Depends on socc_pkg.

// One item is accepted per clock; its result appears in the output register
// on the next cycle. The state update is a single decode between the input
// handshake and the result register, so an item may follow every cycle. The
// output register frees as its result is taken, so input and output stall
// together only while a result waits with m_axis_tready low. Configuration
// writes are always taken.
module steering_override_command_controller #(
  parameter int unsigned REMOTE_HOLD_TICKS = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  socc_pkg::cfg_index_e             cfg_index_i,
  input  logic                             cfg_data_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // cmd_byte [7:0], passthrough_pwm [23:8]
  input  logic [socc_pkg::InDataWidth-1:0]  s_axis_tdata_i,
  // req_type [1:0]
  input  socc_pkg::req_type_e              s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // pwm_us [15:0], override_active [16], relay_on [17], forward_valid [18],
  // forward_byte [26:19], remote_status [28:27], zero [31:29]
  output logic [socc_pkg::OutDataWidth-1:0] m_axis_tdata_o
);
  import socc_pkg::*;

  logic         long_hold_q, fast_report_q;
  logic         override_on_q, override_on_d;
  logic [10:0]  manual_pwm_q, manual_pwm_d;
  logic [5:0]   override_ticks_q, override_ticks_d;
  remote_code_e remote_code_q, remote_code_d;
  logic [7:0]   remote_ticks_q, remote_ticks_d;
  logic         slow_period_q, slow_period_d;
  logic         relay_state_q, relay_state_d;
  logic         out_valid_q;
  result_t      result_q, result_d;

  logic [7:0]   cmd_byte;
  logic [15:0]  pass_pwm;
  logic         accept;
  logic         fwd;
  logic [5:0]   hold;
  logic [4:0]   ovr_offset;
  logic [10:0]  ovr_pwm;

  assign cmd_byte        = s_axis_tdata_i[7:0];
  assign pass_pwm        = s_axis_tdata_i[23:8];
  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = result_q;

  assign hold = long_hold_q ? (slow_period_q ? HoldLongSlow : HoldLongFast)
                            : (slow_period_q ? HoldShortSlow : HoldShortFast);
  assign ovr_offset = 5'(cmd_byte - OvrLowByte);
  assign ovr_pwm    = PwmBase + 11'(ovr_offset) * 11'(PwmStep);

  always_comb begin
    override_on_d    = override_on_q;
    manual_pwm_d     = manual_pwm_q;
    override_ticks_d = override_ticks_q;
    remote_code_d    = remote_code_q;
    remote_ticks_d   = remote_ticks_q;
    slow_period_d    = slow_period_q;
    relay_state_d    = relay_state_q;
    fwd              = 1'b0;
    case (s_axis_tuser_i)
      REQ_HOST: begin
        fwd = (cmd_byte >= FwdLowByte) && (cmd_byte <= FwdHighByte);
        if (cmd_byte == RelayOnByte) begin
          relay_state_d = 1'b1;
        end else if (cmd_byte == RelayOffByte) begin
          relay_state_d = 1'b0;
        end
        if (cmd_byte == CancelByte) begin
          override_on_d    = 1'b0;
          override_ticks_d = '0;
        end
        if ((cmd_byte >= OvrLowByte) && (cmd_byte <= OvrHighByte)) begin
          override_on_d    = 1'b1;
          manual_pwm_d     = ovr_pwm;
          override_ticks_d = hold;
        end
      end
      REQ_SWITCH: begin
        if (cmd_byte == StartByte) begin
          remote_code_d  = REMOTE_START;
          remote_ticks_d = 8'(REMOTE_HOLD_TICKS);
        end else if (cmd_byte == StopByte) begin
          remote_code_d  = REMOTE_STOP;
          remote_ticks_d = 8'(REMOTE_HOLD_TICKS);
        end
      end
      REQ_TICK: begin
        remote_ticks_d = remote_ticks_q - 8'd1;
        if (remote_ticks_d == 8'd0) begin
          remote_code_d = REMOTE_NONE;
        end
        if (override_ticks_q != 6'd0) begin
          override_ticks_d = override_ticks_q - 6'd1;
        end else begin
          override_on_d = 1'b0;
        end
        slow_period_d = !fast_report_q;
      end
      default: begin
      end
    endcase

    result_d.pad             = '0;
    result_d.pwm_us          = override_on_d ? {5'd0, manual_pwm_d} : pass_pwm;
    result_d.override_active = override_on_d;
    result_d.relay_on        = relay_state_d;
    result_d.forward_valid   = fwd;
    result_d.forward_byte    = fwd ? cmd_byte : 8'd0;
    result_d.remote_status   = remote_code_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_hold_q   <= 1'b0;
      fast_report_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LONG_HOLD:   long_hold_q   <= cfg_data_i;
        CFG_FAST_REPORT: fast_report_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      override_on_q    <= 1'b0;
      manual_pwm_q     <= PwmReset;
      override_ticks_q <= '0;
      remote_code_q    <= REMOTE_NONE;
      remote_ticks_q   <= '0;
      slow_period_q    <= 1'b0;
      relay_state_q    <= 1'b0;
    end else if (accept) begin
      override_on_q    <= override_on_d;
      manual_pwm_q     <= manual_pwm_d;
      override_ticks_q <= override_ticks_d;
      remote_code_q    <= remote_code_d;
      remote_ticks_q   <= remote_ticks_d;
      slow_period_q    <= slow_period_d;
      relay_state_q    <= relay_state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

endmodule
